// ===== rtl/gws_pkg.sv =====
// Shared constants and types for the four-way grid word search.
package gws_pkg;

   localparam int MAX_ROWS_DEF = 32;
   localparam int MAX_COLS_DEF = 32;
   localparam int MAX_WORD_DEF = 32;

   localparam int CHAR_W = 8;
   localparam int POS_W  = 5;
   localparam int DIM_W  = 6;
   localparam int CNT_W  = 9;
   localparam int CMD_W  = 2;
   localparam int BUS_W  = 32;
   localparam int ADDR_W = 3;

   localparam logic [DIM_W-1:0] DIM_RESET = 6'd32;

   localparam logic [CMD_W-1:0] CMD_GRID   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_WORD   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;

   localparam logic REG_ROWS = 1'b0;
   localparam logic REG_COLS = 1'b1;

   typedef enum logic [1:0] {
      DIR_RIGHT = 2'd0,
      DIR_LEFT  = 2'd1,
      DIR_DOWN  = 2'd2,
      DIR_UP    = 2'd3
   } dir_type;

endpackage

// ===== rtl/gws_step.sv =====
// Bounds check and probe address for one letter of one direction.
module gws_step #(
   parameter int RW = $clog2(gws_pkg::MAX_ROWS_DEF),
   parameter int CW = $clog2(gws_pkg::MAX_COLS_DEF),
   parameter int KW = $clog2(gws_pkg::MAX_WORD_DEF)
) (
   input  logic [RW-1:0]              row,
   input  logic [CW-1:0]              col,
   input  gws_pkg::dir_type           dir,
   input  logic [KW-1:0]              step,
   input  logic [gws_pkg::DIM_W-1:0]  word_length,
   input  logic [gws_pkg::CNT_W-1:0]  rows,
   input  logic [gws_pkg::CNT_W-1:0]  cols,
   output logic                       dir_ok,
   output logic [RW-1:0]              probe_row,
   output logic [CW-1:0]              probe_col
);
   import gws_pkg::*;

   logic [CNT_W-1:0] r_ext;
   logic [CNT_W-1:0] c_ext;
   logic [CNT_W-1:0] k_ext;
   logic [CNT_W-1:0] len_ext;
   logic [CNT_W-1:0] pr_ext;
   logic [CNT_W-1:0] pc_ext;

   assign r_ext   = CNT_W'(row);
   assign c_ext   = CNT_W'(col);
   assign k_ext   = CNT_W'(step);
   assign len_ext = CNT_W'(word_length);

   always_comb begin
      dir_ok = 1'b0;
      pr_ext = r_ext;
      pc_ext = c_ext;
      case (dir)
         DIR_RIGHT: begin
            dir_ok = (c_ext + len_ext) <= cols;
            pc_ext = c_ext + k_ext;
         end
         DIR_LEFT: begin
            dir_ok = (c_ext + CNT_W'(1)) >= len_ext;
            pc_ext = c_ext - k_ext;
         end
         DIR_DOWN: begin
            dir_ok = (r_ext + len_ext) <= rows;
            pr_ext = r_ext + k_ext;
         end
         DIR_UP: begin
            dir_ok = (r_ext + CNT_W'(1)) >= len_ext;
            pr_ext = r_ext - k_ext;
         end
         default: begin
            dir_ok = 1'b0;
         end
      endcase
   end

   assign probe_row = pr_ext[RW-1:0];
   assign probe_col = pc_ext[CW-1:0];

endmodule

// ===== rtl/grid_word_search_four_way.sv =====
// Top level of the four-way grid word search with grid and word memories.
// Grid and word write requests produce no response and, while no search is running,
// are taken one per cycle. A search request holds off further requests until its
// response is registered: each direction is tried at each cell, each letter is
// compared after a grid and word memory read, then the response is issued.
// Synchronous reset clears control state and sets both grid dimensions to 32.
module grid_word_search_four_way #(
   parameter int MAX_ROWS = gws_pkg::MAX_ROWS_DEF,
   parameter int MAX_COLS = gws_pkg::MAX_COLS_DEF,
   parameter int MAX_WORD = gws_pkg::MAX_WORD_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [gws_pkg::CMD_W-1:0]    req_command,
   input  logic [gws_pkg::POS_W-1:0]    req_row_index,
   input  logic [gws_pkg::POS_W-1:0]    req_col_index,
   input  logic [gws_pkg::CHAR_W-1:0]   req_char_value,
   input  logic [gws_pkg::DIM_W-1:0]    req_word_length,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_found,
   output logic [gws_pkg::POS_W-1:0]    rsp_start_row,
   output logic [gws_pkg::POS_W-1:0]    rsp_start_col,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [gws_pkg::ADDR_W-1:0]   paddr,
   input  logic [gws_pkg::BUS_W-1:0]    pwdata,
   output logic [gws_pkg::BUS_W-1:0]    prdata,
   output logic                         pready
);
   import gws_pkg::*;

   localparam int RW = $clog2(MAX_ROWS);
   localparam int CW = $clog2(MAX_COLS);
   localparam int KW = $clog2(MAX_WORD);
   localparam int GRID_DEPTH = 1 << (RW + CW);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_DIR   = 5'b00010,
      ST_READ  = 5'b00100,
      ST_CHECK = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   logic [CHAR_W-1:0] grid_mem [GRID_DEPTH];
   logic [CHAR_W-1:0] word_mem [MAX_WORD];

   state_type         state_ff, state_in;
   logic [DIM_W-1:0]  grid_rows_ff, grid_cols_ff;
   logic [RW-1:0]     r_ff, r_in;
   logic [CW-1:0]     c_ff, c_in;
   logic [KW-1:0]     k_ff, k_in;
   dir_type           dir_ff, dir_in;
   logic [DIM_W-1:0]  len_ff, len_in;
   logic              hit_ff, hit_in;
   logic [CHAR_W-1:0] grid_q_ff, word_q_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_found_ff, rsp_found_in;
   logic [POS_W-1:0]  rsp_row_ff, rsp_row_in;
   logic [POS_W-1:0]  rsp_col_ff, rsp_col_in;

   logic [CNT_W-1:0]  rows_eff, cols_eff;
   logic [CNT_W-1:0]  req_len_ext, req_row_ext, req_col_ext;
   logic [CNT_W-1:0]  r_ext, c_ext, k_ext;
   logic              req_accept, pre_fail;
   logic              grid_we, word_we;
   logic              last_col, last_row, k_last;
   logic              dir_ok;
   logic [RW-1:0]     probe_row;
   logic [CW-1:0]     probe_col;

   assign pready = 1'b1;
   assign prdata = (paddr[2] == REG_COLS) ? BUS_W'(grid_cols_ff) : BUS_W'(grid_rows_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_rows_ff <= DIM_RESET;
         grid_cols_ff <= DIM_RESET;
      end else if (psel && penable && pwrite && pready) begin
         if (paddr[2] == REG_COLS) begin
            grid_cols_ff <= pwdata[DIM_W-1:0];
         end else begin
            grid_rows_ff <= pwdata[DIM_W-1:0];
         end
      end
   end

   assign rows_eff = (CNT_W'(grid_rows_ff) > CNT_W'(MAX_ROWS)) ? CNT_W'(MAX_ROWS)
                                                              : CNT_W'(grid_rows_ff);
   assign cols_eff = (CNT_W'(grid_cols_ff) > CNT_W'(MAX_COLS)) ? CNT_W'(MAX_COLS)
                                                              : CNT_W'(grid_cols_ff);

   assign req_ready   = (state_ff == ST_IDLE);
   assign req_accept  = req_valid && req_ready;
   assign req_len_ext = CNT_W'(req_word_length);
   assign req_row_ext = CNT_W'(req_row_index);
   assign req_col_ext = CNT_W'(req_col_index);

   assign pre_fail = (req_len_ext == '0) || (req_len_ext > CNT_W'(MAX_WORD)) ||
                     (req_len_ext > rows_eff) || (req_len_ext > cols_eff);

   assign grid_we = req_accept && (req_command == CMD_GRID) &&
                    (req_row_ext < CNT_W'(MAX_ROWS)) && (req_col_ext < CNT_W'(MAX_COLS));
   assign word_we = req_accept && (req_command == CMD_WORD) &&
                    (req_col_ext < CNT_W'(MAX_WORD));

   gws_step #(
      .RW(RW),
      .CW(CW),
      .KW(KW)
   ) u_step (
      .row        (r_ff),
      .col        (c_ff),
      .dir        (dir_ff),
      .step       (k_ff),
      .word_length(len_ff),
      .rows       (rows_eff),
      .cols       (cols_eff),
      .dir_ok     (dir_ok),
      .probe_row  (probe_row),
      .probe_col  (probe_col)
   );

   always_ff @(posedge clock) begin
      if (grid_we) begin
         grid_mem[{req_row_ext[RW-1:0], req_col_ext[CW-1:0]}] <= req_char_value;
      end
      grid_q_ff <= grid_mem[{probe_row, probe_col}];
   end

   always_ff @(posedge clock) begin
      if (word_we) begin
         word_mem[req_col_ext[KW-1:0]] <= req_char_value;
      end
      word_q_ff <= word_mem[k_ff];
   end

   assign r_ext    = CNT_W'(r_ff);
   assign c_ext    = CNT_W'(c_ff);
   assign k_ext    = CNT_W'(k_ff);
   assign last_col = (c_ext + CNT_W'(1)) == cols_eff;
   assign last_row = (r_ext + CNT_W'(1)) == rows_eff;
   assign k_last   = (k_ext + CNT_W'(1)) == CNT_W'(len_ff);

   always_comb begin
      state_in     = state_ff;
      r_in         = r_ff;
      c_in         = c_ff;
      k_in         = k_ff;
      dir_in       = dir_ff;
      len_in       = len_ff;
      hit_in       = hit_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_found_in = rsp_found_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept && (req_command == CMD_SEARCH)) begin
               len_in = req_word_length;
               r_in   = '0;
               c_in   = '0;
               k_in   = '0;
               dir_in = DIR_RIGHT;
               hit_in = 1'b0;
               state_in = pre_fail ? ST_DONE : ST_DIR;
            end
         end
         ST_DIR, ST_CHECK: begin
            if ((state_ff == ST_DIR) && dir_ok) begin
               k_in     = '0;
               state_in = ST_READ;
            end else if ((state_ff == ST_CHECK) && (grid_q_ff == word_q_ff)) begin
               if (k_last) begin
                  hit_in   = 1'b1;
                  state_in = ST_DONE;
               end else begin
                  k_in     = k_ff + 1'b1;
                  state_in = ST_READ;
               end
            end else if (dir_ff != DIR_UP) begin
               case (dir_ff)
                  DIR_RIGHT: dir_in = DIR_LEFT;
                  DIR_LEFT:  dir_in = DIR_DOWN;
                  default:   dir_in = DIR_UP;
               endcase
               state_in = ST_DIR;
            end else if (last_col && last_row) begin
               hit_in   = 1'b0;
               state_in = ST_DONE;
            end else begin
               dir_in = DIR_RIGHT;
               if (last_col) begin
                  c_in = '0;
                  r_in = r_ff + 1'b1;
               end else begin
                  c_in = c_ff + 1'b1;
               end
               state_in = ST_DIR;
            end
         end
         ST_READ: begin
            state_in = ST_CHECK;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = hit_ff;
               rsp_row_in   = hit_ff ? r_ext[POS_W-1:0] : '0;
               rsp_col_in   = hit_ff ? c_ext[POS_W-1:0] : '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      r_ff         <= r_in;
      c_ff         <= c_in;
      k_ff         <= k_in;
      dir_ff       <= dir_in;
      len_ff       <= len_in;
      hit_ff       <= hit_in;
      rsp_found_ff <= rsp_found_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_col_ff   <= rsp_col_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_found     = rsp_found_ff;
   assign rsp_start_row = rsp_row_ff;
   assign rsp_start_col = rsp_col_ff;

endmodule

// ===== dv/gws_search_checker.sv =====
`timescale 1ns / 100ps
// Checker for the grid word search: tracks grid, word and dimensions, predicts and compares.
module gws_search_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_ready,
   input  logic [gws_pkg::CMD_W-1:0]    req_command,
   input  logic [gws_pkg::POS_W-1:0]    req_row_index,
   input  logic [gws_pkg::POS_W-1:0]    req_col_index,
   input  logic [gws_pkg::CHAR_W-1:0]   req_char_value,
   input  logic [gws_pkg::DIM_W-1:0]    req_word_length,
   input  logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  logic                         rsp_found,
   input  logic [gws_pkg::POS_W-1:0]    rsp_start_row,
   input  logic [gws_pkg::POS_W-1:0]    rsp_start_col,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [gws_pkg::ADDR_W-1:0]   paddr,
   input  logic [gws_pkg::BUS_W-1:0]    pwdata,
   input  logic                         pready,
   output int unsigned                  fail_count,
   output int unsigned                  searches_pending
);
   import gws_pkg::*;

   localparam logic [ADDR_W-1:0] ROWS_ADDR = {REG_ROWS, 2'b00};
   localparam logic [ADDR_W-1:0] COLS_ADDR = {REG_COLS, 2'b00};

   typedef struct packed {
      logic              found;
      logic [POS_W-1:0]  row;
      logic [POS_W-1:0]  col;
   } word_hit_type;

   logic [CHAR_W-1:0] grid_chars [MAX_ROWS_DEF][MAX_COLS_DEF];
   logic [CHAR_W-1:0] word_chars [MAX_WORD_DEF];
   logic [DIM_W-1:0]  rows_reg = DIM_RESET;
   logic [DIM_W-1:0]  cols_reg = DIM_RESET;
   word_hit_type      expected_hits [$];
   int unsigned       mismatches = 0;

   // The caller has already checked that the whole run stays inside the grid.
   function automatic bit word_runs(int r, int c, int dr, int dc, int len);
      int k;
      for (k = 0; k < len; k++) begin
         if (grid_chars[r + dr * k][c + dc * k] != word_chars[k]) return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic word_hit_type locate_word(int len);
      word_hit_type hit;
      int nr;
      int nc;
      int r;
      int c;
      hit = '0;
      nr = (rows_reg > MAX_ROWS_DEF) ? MAX_ROWS_DEF : int'(rows_reg);
      nc = (cols_reg > MAX_COLS_DEF) ? MAX_COLS_DEF : int'(cols_reg);
      if (len == 0 || len > MAX_WORD_DEF || len > nr || len > nc) return hit;
      for (r = 0; r < nr; r++) begin
         for (c = 0; c < nc; c++) begin
            if ((c + len <= nc && word_runs(r, c, 0, 1, len)) ||
                (c + 1 >= len && word_runs(r, c, 0, -1, len)) ||
                (r + len <= nr && word_runs(r, c, 1, 0, len)) ||
                (r + 1 >= len && word_runs(r, c, -1, 0, len))) begin
               hit.found = 1'b1;
               hit.row = r[POS_W-1:0];
               hit.col = c[POS_W-1:0];
               return hit;
            end
         end
      end
      return hit;
   endfunction

   always @(posedge clock) begin : monitor
      word_hit_type got;
      word_hit_type want;
      if (reset) begin
         rows_reg = DIM_RESET;
         cols_reg = DIM_RESET;
         expected_hits.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            if (paddr == ROWS_ADDR) begin
               rows_reg = pwdata[DIM_W-1:0];
            end else if (paddr == COLS_ADDR) begin
               cols_reg = pwdata[DIM_W-1:0];
            end
         end
         if (rsp_valid && rsp_ready) begin
            got = {rsp_found, rsp_start_row, rsp_start_col};
            if (expected_hits.size() == 0) begin
               $error("search response with no request outstanding: found %0d row %0d col %0d",
                      got.found, got.row, got.col);
               mismatches++;
            end else begin
               want = expected_hits.pop_front();
               if (got.found !== want.found) begin
                  $error("found mismatch: expected %0d, actual %0d", want.found, got.found);
                  mismatches++;
               end
               if (got.row !== want.row) begin
                  $error("start_row mismatch: expected %0d, actual %0d", want.row, got.row);
                  mismatches++;
               end
               if (got.col !== want.col) begin
                  $error("start_col mismatch: expected %0d, actual %0d", want.col, got.col);
                  mismatches++;
               end
            end
         end
         if (req_valid && req_ready) begin
            case (req_command)
               CMD_GRID: begin
                  grid_chars[req_row_index][req_col_index] = req_char_value;
               end
               CMD_WORD: begin
                  word_chars[req_col_index] = req_char_value;
               end
               CMD_SEARCH: begin
                  expected_hits.push_back(locate_word(int'(req_word_length)));
               end
               default: begin
               end
            endcase
         end
      end
      fail_count <= mismatches;
      searches_pending <= expected_hits.size();
   end

endmodule

// ===== dv/tb_grid_word_search_four_way.sv =====
`timescale 1ns / 100ps
// Testbench top for the grid word search: stimulus, configuration, watchdog and verdict.
module tb_grid_word_search_four_way;
   import gws_pkg::*;

   localparam logic [CMD_W-1:0]  CMD_UNUSED   = 2'd3;
   localparam logic [ADDR_W-1:0] ROWS_ADDR    = {REG_ROWS, 2'b00};
   localparam logic [ADDR_W-1:0] COLS_ADDR    = {REG_COLS, 2'b00};
   localparam logic [CHAR_W-1:0] FIRST_LETTER = "A";
   localparam int ITEM_TARGET   = 650;
   localparam int SETTLE_CYCLES = 16;
   localparam int STALL_LIMIT   = 100000;
   localparam int FIXED_PHASES  = 8;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic [CMD_W-1:0]     req_command;
   logic [POS_W-1:0]     req_row_index;
   logic [POS_W-1:0]     req_col_index;
   logic [CHAR_W-1:0]    req_char_value;
   logic [DIM_W-1:0]     req_word_length;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b1;
   logic                 rsp_found;
   logic [POS_W-1:0]     rsp_start_row;
   logic [POS_W-1:0]     rsp_start_col;
   logic                 psel;
   logic                 penable;
   logic                 pwrite;
   logic [ADDR_W-1:0]    paddr;
   logic [BUS_W-1:0]     pwdata;
   logic [BUS_W-1:0]     prdata;
   logic                 pready;
   int unsigned          fail_count;
   int unsigned          searches_pending;

   bit cell_loaded [MAX_ROWS_DEF][MAX_COLS_DEF];
   bit letter_loaded [MAX_WORD_DEF];
   int rows_used;
   int cols_used;
   int items_sent = 0;
   int calm_left = 0;
   int ready_hold = 0;
   int fixed_rows [FIXED_PHASES] = '{0, 63, 1, 5, 2, 32, 4, 6};
   int fixed_cols [FIXED_PHASES] = '{3, 2, 32, 5, 63, 0, 6, 4};

   always #1 clock = ~clock;

   grid_word_search_four_way u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_command     (req_command),
      .req_row_index   (req_row_index),
      .req_col_index   (req_col_index),
      .req_char_value  (req_char_value),
      .req_word_length (req_word_length),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_found       (rsp_found),
      .rsp_start_row   (rsp_start_row),
      .rsp_start_col   (rsp_start_col),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   gws_search_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_command      (req_command),
      .req_row_index    (req_row_index),
      .req_col_index    (req_col_index),
      .req_char_value   (req_char_value),
      .req_word_length  (req_word_length),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_found        (rsp_found),
      .rsp_start_row    (rsp_start_row),
      .rsp_start_col    (rsp_start_col),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .pready           (pready),
      .fail_count       (fail_count),
      .searches_pending (searches_pending)
   );

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [CHAR_W-1:0] pick_char();
      logic [CHAR_W-1:0] any_byte;
      logic [CHAR_W-1:0] offset;
      any_byte = CHAR_W'($urandom_range(0, 255));
      offset = CHAR_W'($urandom_range(0, 2));
      if ($urandom_range(0, 4) == 0) return any_byte;
      return FIRST_LETTER + offset;
   endfunction

   always @(posedge clock) begin
      if (ready_hold > 0) begin
         ready_hold <= ready_hold - 1;
      end else if ($urandom_range(0, 2) == 0) begin
         rsp_ready <= 1'b0;
         ready_hold <= pick_gap();
      end else begin
         rsp_ready <= 1'b1;
         ready_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(40, 150)
                                                   : $urandom_range(0, 6);
      end
   end

   task automatic send(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] row,
                       input logic [POS_W-1:0] col, input logic [CHAR_W-1:0] ch,
                       input logic [DIM_W-1:0] len);
      int gap;
      if (calm_left > 0) begin
         calm_left--;
         gap = 0;
      end else begin
         gap = pick_gap();
         if ($urandom_range(0, 49) == 0) calm_left = $urandom_range(20, 60);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_row_index <= row;
      req_col_index <= col;
      req_char_value <= ch;
      req_word_length <= len;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (cmd == CMD_GRID) cell_loaded[row][col] = 1'b1;
      if (cmd == CMD_WORD) letter_loaded[col] = 1'b1;
      if (cmd != CMD_UNUSED) items_sent++;
   endtask

   task automatic put_cell(input int row, input int col, input logic [CHAR_W-1:0] ch);
      send(CMD_GRID, POS_W'(row), POS_W'(col), ch, DIM_W'($urandom_range(0, 63)));
   endtask

   task automatic put_letter(input int pos, input logic [CHAR_W-1:0] ch);
      send(CMD_WORD, POS_W'($urandom_range(0, 31)), POS_W'(pos), ch,
           DIM_W'($urandom_range(0, 63)));
   endtask

   // A search that can match reads every word letter below its length, so those are loaded first.
   task automatic run_search(input int len);
      int k;
      if (len >= 1 && len <= MAX_WORD_DEF && len <= rows_used && len <= cols_used) begin
         for (k = 0; k < len; k++) begin
            if (!letter_loaded[k]) put_letter(k, pick_char());
         end
      end
      send(CMD_SEARCH, POS_W'($urandom_range(0, 31)), POS_W'($urandom_range(0, 31)),
           CHAR_W'($urandom_range(0, 255)), DIM_W'(len));
   endtask

   task automatic write_reg(input logic [ADDR_W-1:0] addr, input int value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (searches_pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic program_dims(input int rows_val, input int cols_val);
      write_reg(ROWS_ADDR, rows_val);
      write_reg(COLS_ADDR, cols_val);
      rows_used = (rows_val > MAX_ROWS_DEF) ? MAX_ROWS_DEF : rows_val;
      cols_used = (cols_val > MAX_COLS_DEF) ? MAX_COLS_DEF : cols_val;
   endtask

   // Every cell inside the active grid is loaded before any search can scan it.
   task automatic apply_dims(input int rows_val, input int cols_val);
      int r;
      int c;
      settle();
      program_dims(rows_val, cols_val);
      for (r = 0; r < rows_used; r++) begin
         for (c = 0; c < cols_used; c++) begin
            if (!cell_loaded[r][c]) put_cell(r, c, pick_char());
         end
      end
   endtask

   task automatic plant_and_search(input bit plant);
      int span;
      int len;
      int k;
      int r;
      int c;
      int dr;
      int dc;
      dir_type heading;
      logic [CHAR_W-1:0] letters [MAX_WORD_DEF];
      span = (rows_used < cols_used) ? rows_used : cols_used;
      if (span > MAX_WORD_DEF) span = MAX_WORD_DEF;
      if (span == 0) begin
         run_search($urandom_range(1, 3));
         return;
      end
      if ($urandom_range(0, 4) == 0) begin
         len = $urandom_range(1, span);
      end else begin
         len = $urandom_range(1, (span < 4) ? span : 4);
      end
      for (k = 0; k < len; k++) begin
         letters[k] = pick_char();
         put_letter(k, letters[k]);
      end
      if (plant) begin
         heading = dir_type'($urandom_range(0, 3));
         r = 0;
         c = 0;
         dr = 0;
         dc = 1;
         case (heading)
            DIR_RIGHT: begin
               r = $urandom_range(0, rows_used - 1);
               c = $urandom_range(0, cols_used - len);
               dr = 0;
               dc = 1;
            end
            DIR_LEFT: begin
               r = $urandom_range(0, rows_used - 1);
               c = $urandom_range(len - 1, cols_used - 1);
               dr = 0;
               dc = -1;
            end
            DIR_DOWN: begin
               r = $urandom_range(0, rows_used - len);
               c = $urandom_range(0, cols_used - 1);
               dr = 1;
               dc = 0;
            end
            DIR_UP: begin
               r = $urandom_range(len - 1, rows_used - 1);
               c = $urandom_range(0, cols_used - 1);
               dr = -1;
               dc = 0;
            end
            default: begin
               r = 0;
               c = 0;
               dr = 0;
               dc = 1;
            end
         endcase
         for (k = 0; k < len; k++) put_cell(r + dr * k, c + dc * k, letters[k]);
      end
      run_search(len);
   endtask

   task automatic random_step();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
         plant_and_search(1'b1);
      end else if (roll < 70) begin
         plant_and_search(1'b0);
      end else if (roll < 80) begin
         put_cell($urandom_range(0, 31), $urandom_range(0, 31),
                  CHAR_W'($urandom_range(0, 255)));
      end else if (roll < 86) begin
         put_letter($urandom_range(0, 31), CHAR_W'($urandom_range(0, 255)));
      end else if (roll < 90) begin
         send(CMD_UNUSED, POS_W'($urandom_range(0, 31)), POS_W'($urandom_range(0, 31)),
              CHAR_W'($urandom_range(0, 255)), DIM_W'($urandom_range(0, 63)));
      end else begin
         run_search($urandom_range(0, 63));
      end
   endtask

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (psel && penable && pready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("tb_grid_word_search_four_way failed");
      $finish;
   end

   initial begin : stimulus
      int phase;
      int step;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_command <= CMD_GRID;
      req_row_index <= '0;
      req_col_index <= '0;
      req_char_value <= '0;
      req_word_length <= '0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // A three by three grid with distinct letters so each hit below has one answer.
      program_dims(3, 3);
      put_cell(0, 0, 8'h00);
      put_cell(0, 1, "B");
      put_cell(0, 2, "C");
      put_cell(1, 0, "D");
      put_cell(1, 1, "E");
      put_cell(1, 2, "F");
      put_cell(2, 0, "G");
      put_cell(2, 1, "H");
      put_cell(2, 2, 8'hFF);
      put_cell(31, 31, 8'hFF);
      send(CMD_UNUSED, '1, '1, '1, '1);
      put_letter(0, "E");
      run_search(1);
      run_search(0);
      run_search(63);
      run_search(4);
      put_letter(0, "C");
      put_letter(1, "B");
      put_letter(2, 8'h00);
      run_search(3);
      put_letter(0, "G");
      put_letter(1, "D");
      run_search(3);
      put_letter(31, 8'hFF);

      phase = 0;
      while (items_sent < ITEM_TARGET) begin
         if (phase < FIXED_PHASES) begin
            apply_dims(fixed_rows[phase], fixed_cols[phase]);
         end else begin
            apply_dims($urandom_range(1, 7), $urandom_range(1, 7));
         end
         for (step = 0; step < 20 && items_sent < ITEM_TARGET; step++) random_step();
         phase++;
      end
      settle();

      if (fail_count == 0 && searches_pending == 0) begin
         $display("tb_grid_word_search_four_way passed");
      end else begin
         $display("tb_grid_word_search_four_way failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/gws_pkg.sv
rtl/gws_step.sv
rtl/grid_word_search_four_way.sv
dv/gws_search_checker.sv
dv/tb_grid_word_search_four_way.sv
